// ----- design/gpio_port_safe_reconfigure_unit_macros.svh -----
// assertion macros shared by the gpio port reconfigure unit
`ifndef GPIO_PORT_SAFE_RECONFIGURE_UNIT_MACROS_SVH
`define GPIO_PORT_SAFE_RECONFIGURE_UNIT_MACROS_SVH

// same-cycle implication under synchronous reset
`define GPSR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define GPSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/gpio_psr_pkg.sv -----
// types, codes and constants of the gpio port reconfigure unit
package gpio_psr_pkg;

   localparam int PIN_COUNT_DEF   = 16;
   localparam int PORT_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [2:0] {
      REQ_CONFIGURE   = 3'd0,
      REQ_WRITE_LATCH = 3'd1,
      REQ_READ_PADS   = 3'd2,
      REQ_READ_LATCH  = 3'd3,
      REQ_READ_PIN    = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_LOCKED  = 2'd2,
      ST_HANDOFF = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_INPUT     = 2'd0,
      MODE_OUTPUT    = 2'd1,
      MODE_ALTERNATE = 2'd2,
      MODE_ANALOG    = 2'd3
   } mode_type;

   localparam logic [1:0] PULL_INVALID = 2'd3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOCK_ACTIVE = 1'b0,
      CSR_LOCKED_PINS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [PORT_WIDTH-1:0] pin_mask;
      logic [1:0]            new_mode;
      logic [1:0]            new_pull;
      logic [1:0]            new_speed;
      logic                  new_open_drain;
      logic [3:0]            new_alternate;
      logic [PORT_WIDTH-1:0] data_bits;
      logic [3:0]            pin_number;
      logic [PORT_WIDTH-1:0] pad_levels;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [PORT_WIDTH-1:0] read_data;
      logic [1:0]            pin_mode;
      logic [1:0]            pin_pull;
      logic [1:0]            pin_speed;
      logic                  pin_open_drain;
      logic [3:0]            pin_alternate;
   } rsp_beat_type;

endpackage

// ----- design/gpio_psr_req_if.sv -----
// request channel of the gpio port reconfigure unit
interface gpio_psr_req_if import gpio_psr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            req_type;
   logic [PORT_WIDTH-1:0] pin_mask;
   logic [1:0]            new_mode;
   logic [1:0]            new_pull;
   logic [1:0]            new_speed;
   logic                  new_open_drain;
   logic [3:0]            new_alternate;
   logic [PORT_WIDTH-1:0] data_bits;
   logic [3:0]            pin_number;
   logic [PORT_WIDTH-1:0] pad_levels;

   modport source (
      output valid, req_type, pin_mask, new_mode, new_pull, new_speed,
             new_open_drain, new_alternate, data_bits, pin_number, pad_levels,
      input  ready
   );

   modport sink (
      input  valid, req_type, pin_mask, new_mode, new_pull, new_speed,
             new_open_drain, new_alternate, data_bits, pin_number, pad_levels,
      output ready
   );
endinterface

// ----- design/gpio_psr_rsp_if.sv -----
// response channel of the gpio port reconfigure unit
interface gpio_psr_rsp_if import gpio_psr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [PORT_WIDTH-1:0] read_data;
   logic [1:0]            pin_mode;
   logic [1:0]            pin_pull;
   logic [1:0]            pin_speed;
   logic                  pin_open_drain;
   logic [3:0]            pin_alternate;

   modport source (
      output valid, status, read_data, pin_mode, pin_pull, pin_speed,
             pin_open_drain, pin_alternate,
      input  ready
   );

   modport sink (
      input  valid, status, read_data, pin_mode, pin_pull, pin_speed,
             pin_open_drain, pin_alternate,
      output ready
   );
endinterface

// ----- design/gpio_psr_engine.sv -----
// per-pin configuration state, request checks and atomic update
module gpio_psr_engine import gpio_psr_pkg::*; #(
   parameter int PIN_COUNT = PIN_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  req_beat_type          req_beat,
   input  logic                  lock_active,
   input  logic [PORT_WIDTH-1:0] locked_pins,
   output rsp_beat_type          rsp_beat
);

   localparam logic [PORT_WIDTH-1:0] PORT_MASK =
      PORT_WIDTH'((32'd1 << PIN_COUNT) - 32'd1);

   logic [1:0]           mode_ff  [PIN_COUNT];
   logic [1:0]           mode_in  [PIN_COUNT];
   logic [1:0]           pull_ff  [PIN_COUNT];
   logic [1:0]           pull_in  [PIN_COUNT];
   logic [1:0]           speed_ff [PIN_COUNT];
   logic [1:0]           speed_in [PIN_COUNT];
   logic [3:0]           alt_ff   [PIN_COUNT];
   logic [3:0]           alt_in   [PIN_COUNT];
   logic [PIN_COUNT-1:0] od_ff;
   logic [PIN_COUNT-1:0] od_in;
   logic [PIN_COUNT-1:0] latch_ff;
   logic [PIN_COUNT-1:0] latch_in;

   logic [PORT_WIDTH-1:0] mask;
   logic [PIN_COUNT-1:0]  pin_sel;
   logic [PIN_COUNT-1:0]  handoff_pin;
   logic [PIN_COUNT-1:0]  new_latch;
   logic                  lock_hit;
   logic                  cfg_invalid;
   status_type            cfg_status;
   logic                  pin_ok;
   rsp_beat_type          pin_view;

   always_comb begin
      mask     = req_beat.pin_mask & PORT_MASK;
      pin_sel  = mask[PIN_COUNT-1:0];
      lock_hit = lock_active && (|(locked_pins & mask));
      cfg_invalid = (mask == '0) || (req_beat.new_pull == PULL_INVALID);
      for (int i = 0; i < PIN_COUNT; i++) begin
         handoff_pin[i] = pin_sel[i] &&
            ((mode_ff[i] == MODE_ALTERNATE &&
              (req_beat.new_mode == MODE_OUTPUT ||
               (req_beat.new_mode == MODE_ALTERNATE &&
                (alt_ff[i] != req_beat.new_alternate ||
                 speed_ff[i] != req_beat.new_speed ||
                 pull_ff[i] != req_beat.new_pull ||
                 od_ff[i] != req_beat.new_open_drain)))) ||
             (mode_ff[i] == MODE_OUTPUT && req_beat.new_mode == MODE_ALTERNATE));
      end
      if (cfg_invalid) begin
         cfg_status = ST_INVALID;
      end else if (lock_hit) begin
         cfg_status = ST_LOCKED;
      end else if (|handoff_pin) begin
         cfg_status = ST_HANDOFF;
      end else begin
         cfg_status = ST_OK;
      end
   end

   // pin read-back select
   always_comb begin
      pin_ok   = {1'b0, req_beat.pin_number} < 5'(PIN_COUNT);
      pin_view = '0;
      for (int i = 0; i < PIN_COUNT; i++) begin
         if (req_beat.pin_number == 4'(i)) begin
            pin_view.pin_mode       = mode_ff[i];
            pin_view.pin_pull       = pull_ff[i];
            pin_view.pin_speed      = speed_ff[i];
            pin_view.pin_open_drain = od_ff[i];
            pin_view.pin_alternate  = alt_ff[i];
         end
      end
   end

   always_comb begin
      rsp_beat = '0;
      case (req_beat.req_type)
         REQ_CONFIGURE: begin
            rsp_beat.status = cfg_status;
         end
         REQ_WRITE_LATCH: begin
            rsp_beat.status = ST_OK;
         end
         REQ_READ_PADS: begin
            rsp_beat.status    = ST_OK;
            rsp_beat.read_data = req_beat.pad_levels & mask;
         end
         REQ_READ_LATCH: begin
            rsp_beat.status    = ST_OK;
            rsp_beat.read_data = PORT_WIDTH'(latch_ff) & mask;
         end
         REQ_READ_PIN: begin
            if (pin_ok) begin
               rsp_beat        = pin_view;
               rsp_beat.status = ST_OK;
            end else begin
               rsp_beat.status = ST_INVALID;
            end
         end
         default: begin
            rsp_beat.status = ST_INVALID;
         end
      endcase
   end

   // next state: one atomic update per committed beat
   always_comb begin
      mode_in   = mode_ff;
      pull_in   = pull_ff;
      speed_in  = speed_ff;
      alt_in    = alt_ff;
      od_in     = od_ff;
      latch_in  = latch_ff;
      new_latch = (latch_ff & ~pin_sel) | (req_beat.data_bits[PIN_COUNT-1:0] & pin_sel);
      if (commit && req_beat.req_type == REQ_CONFIGURE && cfg_status == ST_OK) begin
         for (int i = 0; i < PIN_COUNT; i++) begin
            if (pin_sel[i]) begin
               mode_in[i]  = req_beat.new_mode;
               pull_in[i]  = req_beat.new_pull;
               speed_in[i] = req_beat.new_speed;
               alt_in[i]   = req_beat.new_alternate;
            end
         end
         od_in = req_beat.new_open_drain ? (od_ff | pin_sel) : (od_ff & ~pin_sel);
         if (req_beat.new_mode == MODE_OUTPUT) begin
            latch_in = new_latch;
         end
      end else if (commit && req_beat.req_type == REQ_WRITE_LATCH) begin
         latch_in = new_latch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIN_COUNT; i++) begin
            mode_ff[i]  <= MODE_INPUT;
            pull_ff[i]  <= '0;
            speed_ff[i] <= '0;
            alt_ff[i]   <= '0;
         end
         od_ff    <= '0;
         latch_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         pull_ff  <= pull_in;
         speed_ff <= speed_in;
         alt_ff   <= alt_in;
         od_ff    <= od_in;
         latch_ff <= latch_in;
      end
   end

endmodule

// ----- design/gpio_port_safe_reconfigure_unit.sv -----
// top level of the gpio port reconfigure unit
// flow: a result beat is offered from the result register once its request beat has left the input register
// throughput: one beat per cycle while the result side takes beats, set by the input and result registers
// reset (synchronous): clears both valid flags, the lock registers and all pin state
`include "gpio_port_safe_reconfigure_unit_macros.svh"

module gpio_port_safe_reconfigure_unit import gpio_psr_pkg::*; #(
   parameter int PIN_COUNT = PIN_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   gpio_psr_req_if.sink               req_ch,
   gpio_psr_rsp_if.source             rsp_ch,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic                  lock_active_ff;
   logic                  lock_active_in;
   logic [PORT_WIDTH-1:0] locked_pins_ff;
   logic [PORT_WIDTH-1:0] locked_pins_in;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_beat_type in_beat_ff;
   req_beat_type in_beat_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_beat_type out_beat_ff;
   rsp_beat_type out_beat_in;

   req_beat_type req_beat;
   rsp_beat_type eng_beat;
   logic         advance;
   logic         load;

   always_comb begin
      lock_active_in = lock_active_ff;
      locked_pins_in = locked_pins_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LOCK_ACTIVE: lock_active_in = csr_write_data[0];
            CSR_LOCKED_PINS: locked_pins_in = csr_write_data[PORT_WIDTH-1:0];
            default: begin
               lock_active_in = lock_active_ff;
            end
         endcase
      end
   end

   always_comb begin
      req_beat.req_type       = req_ch.req_type;
      req_beat.pin_mask       = req_ch.pin_mask;
      req_beat.new_mode       = req_ch.new_mode;
      req_beat.new_pull       = req_ch.new_pull;
      req_beat.new_speed      = req_ch.new_speed;
      req_beat.new_open_drain = req_ch.new_open_drain;
      req_beat.new_alternate  = req_ch.new_alternate;
      req_beat.data_bits      = req_ch.data_bits;
      req_beat.pin_number     = req_ch.pin_number;
      req_beat.pad_levels     = req_ch.pad_levels;
   end

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign load          = req_ch.valid && req_ch.ready;
   assign in_valid_in   = load || (in_valid_ff && !advance);
   assign in_beat_in    = load ? req_beat : in_beat_ff;
   assign out_valid_in  = advance || (out_valid_ff && !rsp_ch.ready);
   assign out_beat_in   = advance ? eng_beat : out_beat_ff;

   gpio_psr_engine #(
      .PIN_COUNT (PIN_COUNT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .commit      (advance),
      .req_beat    (in_beat_ff),
      .lock_active (lock_active_ff),
      .locked_pins (locked_pins_ff),
      .rsp_beat    (eng_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_active_ff <= 1'b0;
         locked_pins_ff <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         lock_active_ff <= lock_active_in;
         locked_pins_ff <= locked_pins_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff  <= in_beat_in;
      out_beat_ff <= out_beat_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_beat_ff.status;
   assign rsp_ch.read_data      = out_beat_ff.read_data;
   assign rsp_ch.pin_mode       = out_beat_ff.pin_mode;
   assign rsp_ch.pin_pull       = out_beat_ff.pin_pull;
   assign rsp_ch.pin_speed      = out_beat_ff.pin_speed;
   assign rsp_ch.pin_open_drain = out_beat_ff.pin_open_drain;
   assign rsp_ch.pin_alternate  = out_beat_ff.pin_alternate;

   `GPSR_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, out_valid_ff, "beat lost between stages")
   `GPSR_ASSERT_NEXT(a_held_input_kept, clock, reset, in_valid_ff && !advance, in_valid_ff, "held request beat dropped")
   `GPSR_ASSERT_SAME(a_error_beat_clean, clock, reset, out_valid_ff && out_beat_ff.status != ST_OK, out_beat_ff.read_data == '0 && out_beat_ff.pin_mode == '0 && out_beat_ff.pin_alternate == '0, "error beat carries data")

endmodule

// ----- test/gpio_port_safe_reconfigure_unit_test.sv -----
// self-checking testbench of the gpio port reconfigure unit with a scoreboard class
module gpio_port_safe_reconfigure_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gpio_psr_pkg::*;

   localparam logic [PORT_WIDTH-1:0] PORT_PINS = PORT_WIDTH'((1 << PIN_COUNT_DEF) - 1);
   localparam logic [2:0] REQ_UNKNOWN_LOW = 3'd5;
   localparam logic [2:0] REQ_UNKNOWN_TOP = 3'd7;
   localparam logic [1:0] PULL_NONE = 2'd0;
   localparam logic [1:0] PULL_UP = 2'd1;
   localparam logic [1:0] PULL_DOWN = 2'd2;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 255;
   localparam int PHASES = 6;

   class port_scoreboard;
      logic                  lock_key;
      logic [PORT_WIDTH-1:0] frozen_pins;
      mode_type              mode_tbl[PORT_WIDTH];
      logic [1:0]            pull_tbl[PORT_WIDTH];
      logic [1:0]            speed_tbl[PORT_WIDTH];
      logic [3:0]            alt_tbl[PORT_WIDTH];
      logic [PORT_WIDTH-1:0] od_bits;
      logic [PORT_WIDTH-1:0] latch_bits;
      rsp_beat_type          expected_rsp[$];
      int unsigned           errors;
      int unsigned           requests;
      int unsigned           applied;
      int unsigned           status_seen[4];

      function new();
         lock_key = 1'b0;
         frozen_pins = '0;
         od_bits = '0;
         latch_bits = '0;
         foreach (mode_tbl[p]) begin
            mode_tbl[p] = MODE_INPUT;
            pull_tbl[p] = '0;
            speed_tbl[p] = '0;
            alt_tbl[p] = '0;
         end
         errors = 0;
         requests = 0;
         applied = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_LOCK_ACTIVE: lock_key = value[0];
            CSR_LOCKED_PINS: frozen_pins = value[PORT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_beat_type r);
         rsp_beat_type          e;
         logic [PORT_WIDTH-1:0] mask;
         status_type            st;
         e = '0;
         mask = r.pin_mask & PORT_PINS;
         case (r.req_type)
            REQ_CONFIGURE: begin
               st = ST_OK;
               if (mask == '0 || r.new_pull == PULL_INVALID) begin
                  st = ST_INVALID;
               end else if (lock_key && (frozen_pins & mask) != '0) begin
                  st = ST_LOCKED;
               end else begin
                  for (int p = 0; p < PORT_WIDTH; p++) begin
                     if (mask[p] && mode_tbl[p] == MODE_ALTERNATE &&
                         (r.new_mode == MODE_OUTPUT ||
                          (r.new_mode == MODE_ALTERNATE &&
                           (alt_tbl[p] != r.new_alternate || speed_tbl[p] != r.new_speed ||
                            pull_tbl[p] != r.new_pull || od_bits[p] != r.new_open_drain))))
                        st = ST_HANDOFF;
                     if (mask[p] && mode_tbl[p] == MODE_OUTPUT && r.new_mode == MODE_ALTERNATE)
                        st = ST_HANDOFF;
                  end
               end
               if (st == ST_OK) begin
                  for (int p = 0; p < PORT_WIDTH; p++) begin
                     if (mask[p]) begin
                        mode_tbl[p] = mode_type'(r.new_mode);
                        pull_tbl[p] = r.new_pull;
                        speed_tbl[p] = r.new_speed;
                        alt_tbl[p] = r.new_alternate;
                        od_bits[p] = r.new_open_drain;
                     end
                  end
                  if (r.new_mode == MODE_OUTPUT)
                     latch_bits = (latch_bits & ~mask) | (r.data_bits & mask);
                  applied++;
               end
               e.status = st;
            end
            REQ_WRITE_LATCH: begin
               latch_bits = (latch_bits & ~mask) | (r.data_bits & mask);
               e.status = ST_OK;
            end
            REQ_READ_PADS: begin
               e.status = ST_OK;
               e.read_data = r.pad_levels & mask;
            end
            REQ_READ_LATCH: begin
               e.status = ST_OK;
               e.read_data = latch_bits & mask;
            end
            REQ_READ_PIN: begin
               if (r.pin_number >= PIN_COUNT_DEF) begin
                  e.status = ST_INVALID;
               end else begin
                  e.status = ST_OK;
                  e.pin_mode = mode_tbl[r.pin_number];
                  e.pin_pull = pull_tbl[r.pin_number];
                  e.pin_speed = speed_tbl[r.pin_number];
                  e.pin_open_drain = od_bits[r.pin_number];
                  e.pin_alternate = alt_tbl[r.pin_number];
               end
            end
            default: e.status = ST_INVALID;
         endcase
         status_seen[e.status]++;
         requests++;
         expected_rsp.push_back(e);
      endfunction

      function void compare_field(string name, logic [PORT_WIDTH-1:0] e,
                                  logic [PORT_WIDTH-1:0] a);
         if (a !== e) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_response(rsp_beat_type a);
         rsp_beat_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: status expected none actual %0h", $time, a.status);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         compare_field("status", e.status, a.status);
         compare_field("read_data", e.read_data, a.read_data);
         compare_field("pin_mode", e.pin_mode, a.pin_mode);
         compare_field("pin_pull", e.pin_pull, a.pin_pull);
         compare_field("pin_speed", e.pin_speed, a.pin_speed);
         compare_field("pin_open_drain", e.pin_open_drain, a.pin_open_drain);
         compare_field("pin_alternate", e.pin_alternate, a.pin_alternate);
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;
   logic                       hold_off_pending = 1'b0;
   int unsigned                sent_count = 0;
   int unsigned                lock_settings = 0;
   port_scoreboard             sb = new();

   gpio_psr_req_if req_ch();
   gpio_psr_rsp_if rsp_ch();

   gpio_port_safe_reconfigure_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin : monitor
      req_beat_type rq;
      rsp_beat_type rs;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            rq.req_type = req_ch.req_type;
            rq.pin_mask = req_ch.pin_mask;
            rq.new_mode = req_ch.new_mode;
            rq.new_pull = req_ch.new_pull;
            rq.new_speed = req_ch.new_speed;
            rq.new_open_drain = req_ch.new_open_drain;
            rq.new_alternate = req_ch.new_alternate;
            rq.data_bits = req_ch.data_bits;
            rq.pin_number = req_ch.pin_number;
            rq.pad_levels = req_ch.pad_levels;
            sb.note_request(rq);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rs.status = rsp_ch.status;
            rs.read_data = rsp_ch.read_data;
            rs.pin_mode = rsp_ch.pin_mode;
            rs.pin_pull = rsp_ch.pin_pull;
            rs.pin_speed = rsp_ch.pin_speed;
            rs.pin_open_drain = rsp_ch.pin_open_drain;
            rs.pin_alternate = rsp_ch.pin_alternate;
            sb.check_response(rs);
         end
      end
   end

   // result side: short random stalls, quiet stretches and one long hold-off
   initial begin
      int unsigned stall;
      int unsigned taken;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = (taken % 96 < 24) ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   function automatic req_beat_type mk(logic [2:0] kind, logic [15:0] mask, logic [1:0] mode,
                                       logic [1:0] pull, logic [1:0] speed, logic od,
                                       logic [3:0] alt, logic [15:0] data, logic [3:0] pin,
                                       logic [15:0] pads);
      req_beat_type b;
      b.req_type = kind;
      b.pin_mask = mask;
      b.new_mode = mode;
      b.new_pull = pull;
      b.new_speed = speed;
      b.new_open_drain = od;
      b.new_alternate = alt;
      b.data_bits = data;
      b.pin_number = pin;
      b.pad_levels = pads;
      return b;
   endfunction

   function automatic req_beat_type random_request();
      req_beat_type b;
      int unsigned  pick;
      int unsigned  p;
      b = mk(REQ_CONFIGURE, 16'($urandom), 2'($urandom), 2'($urandom_range(0, 2)),
             2'($urandom), 1'($urandom), 4'($urandom), 16'($urandom), 4'($urandom),
             16'($urandom));
      if ($urandom_range(0, 11) == 0) b.new_pull = PULL_INVALID;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         case ($urandom_range(0, 9))
            0, 1, 2: b.pin_mask = 16'd1 << $urandom_range(0, 15);
            3, 4: begin
               // reapply a pin's current settings so alternate pins can be touched
               p = $urandom_range(0, 15);
               b.pin_mask = 16'd1 << p;
               b.new_mode = sb.mode_tbl[p];
               b.new_pull = sb.pull_tbl[p];
               b.new_speed = sb.speed_tbl[p];
               b.new_open_drain = sb.od_bits[p];
               b.new_alternate = sb.alt_tbl[p];
            end
            5: b.pin_mask = 16'($urandom) & 16'($urandom);
            default: ;
         endcase
      end else if (pick < 50) begin
         b.req_type = REQ_WRITE_LATCH;
      end else if (pick < 62) begin
         b.req_type = REQ_READ_PADS;
      end else if (pick < 74) begin
         b.req_type = REQ_READ_LATCH;
      end else if (pick < 95) begin
         b.req_type = REQ_READ_PIN;
      end else begin
         b.req_type = 3'($urandom_range(REQ_UNKNOWN_LOW, REQ_UNKNOWN_TOP));
      end
      if ($urandom_range(0, 19) == 0) b.pin_mask = '0;
      return b;
   endfunction

   task automatic put_payload(req_beat_type b);
      req_ch.req_type <= b.req_type;
      req_ch.pin_mask <= b.pin_mask;
      req_ch.new_mode <= b.new_mode;
      req_ch.new_pull <= b.new_pull;
      req_ch.new_speed <= b.new_speed;
      req_ch.new_open_drain <= b.new_open_drain;
      req_ch.new_alternate <= b.new_alternate;
      req_ch.data_bits <= b.data_bits;
      req_ch.pin_number <= b.pin_number;
      req_ch.pad_levels <= b.pad_levels;
   endtask

   task automatic send_request(req_beat_type b);
      int unsigned gap;
      gap = (sent_count % 128 < 40) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      put_payload(b);
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic wait_idle();
      int unsigned waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(idx, value);
   endtask

   initial begin
      logic                      key;
      logic [CSR_DATA_WIDTH-1:0] pins;
      req_ch.valid <= 1'b0;
      put_payload('0);
      csr_write_enable <= 1'b0;
      csr_index <= CSR_LOCK_ACTIVE;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset state, invalid cases, latch paths and handoff rules
      send_request(mk(REQ_READ_PIN, 16'h0000, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_PIN, 16'hFFFF, MODE_ANALOG, PULL_INVALID, 2'd3, 1'b1, 4'hF,
                      16'hFFFF, 4'd15, 16'hFFFF));
      send_request(mk(REQ_CONFIGURE, 16'h0000, MODE_OUTPUT, PULL_UP, 2'd1, 1'b0, 4'h1,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h000F, MODE_OUTPUT, PULL_INVALID, 2'd1, 1'b0, 4'h1,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h000F, MODE_OUTPUT, PULL_UP, 2'd3, 1'b1, 4'hF,
                      16'h000A, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_LATCH, 16'hFFFF, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'hFFFF));
      send_request(mk(REQ_WRITE_LATCH, 16'hFFFF, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_LATCH, 16'h00F0, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_LATCH, 16'h0000, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_PADS, 16'hFFFF, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h5A5A));
      send_request(mk(REQ_READ_PADS, 16'h0000, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'hFFFF));
      send_request(mk(REQ_CONFIGURE, 16'h0010, MODE_ALTERNATE, PULL_UP, 2'd2, 1'b1, 4'h5,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h0010, MODE_ALTERNATE, PULL_UP, 2'd2, 1'b1, 4'h6,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h0010, MODE_OUTPUT, PULL_UP, 2'd2, 1'b1, 4'h5,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h0001, MODE_ALTERNATE, PULL_UP, 2'd3, 1'b1, 4'hF,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h0010, MODE_ALTERNATE, PULL_UP, 2'd2, 1'b1, 4'h5,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_PIN, 16'h0000, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd4, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h0010, MODE_ANALOG, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_UNKNOWN_LOW, 16'hFFFF, MODE_OUTPUT, PULL_UP, 2'd1, 1'b1, 4'h1,
                      16'hFFFF, 4'd1, 16'hFFFF));
      send_request(mk(REQ_UNKNOWN_TOP, 16'hFFFF, MODE_OUTPUT, PULL_UP, 2'd1, 1'b1, 4'h1,
                      16'hFFFF, 4'd1, 16'hFFFF));
      send_request(mk(REQ_WRITE_LATCH, 16'h0000, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'hFFFF, MODE_INPUT, PULL_DOWN, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_LATCH, 16'hFFFF, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h0000));
      wait_idle();

      // lock on the top pin only
      write_register(CSR_LOCK_ACTIVE, 16'h0001);
      write_register(CSR_LOCKED_PINS, 16'h8000);
      lock_settings++;
      send_request(mk(REQ_CONFIGURE, 16'h8001, MODE_OUTPUT, PULL_NONE, 2'd1, 1'b0, 4'h0,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_CONFIGURE, 16'h0001, MODE_OUTPUT, PULL_NONE, 2'd1, 1'b0, 4'h0,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_WRITE_LATCH, 16'h8000, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'hFFFF, 4'd0, 16'h0000));
      send_request(mk(REQ_READ_LATCH, 16'hFFFF, MODE_INPUT, PULL_NONE, 2'd0, 1'b0, 4'h0,
                      16'h0000, 4'd0, 16'h0000));
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin key = 1'b0; pins = 16'hFFFF; end
            1: begin key = 1'b1; pins = 16'h0000; end
            2: begin key = 1'b1; pins = 16'($urandom); end
            3: begin key = 1'b1; pins = 16'hFFFF; end
            4: begin key = 1'b1; pins = 16'($urandom) & 16'($urandom); end
            default: begin key = 1'b0; pins = 16'h0000; end
         endcase
         write_register(CSR_LOCK_ACTIVE, {15'd0, key});
         write_register(CSR_LOCKED_PINS, pins);
         lock_settings++;
         if (ph == 0) hold_off_pending = 1'b1;
         repeat (PHASE_BEATS) send_request(random_request());
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: result beats expected %0d actual 0", $time, sb.pending());
         sb.errors++;
      end
      $display("covered %0d request beats under %0d lock settings, %0d reconfigurations applied",
               sb.requests, lock_settings, sb.applied);
      $display("status counts: ok %0d, invalid %0d, locked %0d, handoff %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_INVALID],
               sb.status_seen[ST_LOCKED], sb.status_seen[ST_HANDOFF]);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
